### src/gzip_header_parser_assert.svh
// ----------------------------------------------------------------------------
// gzip header parser assertion macros
// Concurrent assertion wrappers clocked on clk and reported through $error.
// ----------------------------------------------------------------------------
`ifndef GZIP_HEADER_PARSER_ASSERT_SVH
`define GZIP_HEADER_PARSER_ASSERT_SVH

// Checked at every edge outside of reset.
`define GHP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define GHP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/ghp_pkg.sv
// ----------------------------------------------------------------------------
// gzip header parser package
// Transaction types, parse phases, status codes and flag constants.
// ----------------------------------------------------------------------------
`default_nettype none

package ghp_pkg;

  localparam logic [15:0] GZ_MAGIC       = 16'h8B1F;
  localparam logic [7:0]  MAGIC_FIRST    = GZ_MAGIC[7:0];
  localparam logic [7:0]  MAGIC_SECOND   = GZ_MAGIC[15:8];
  localparam logic [7:0]  METHOD_DEFLATE = 8'h08;
  localparam logic [7:0]  FLG_RESERVED   = 8'hE0;
  localparam logic [7:0]  FLG_EXTRA      = 8'h04;
  localparam logic [7:0]  FLG_NAME       = 8'h08;
  localparam logic [7:0]  FLG_COMMENT    = 8'h10;
  localparam logic [7:0]  FLG_HCRC       = 8'h02;
  localparam logic [15:0] FIXED_LEN      = 16'd6;
  localparam logic [15:0] HCRC_LEN       = 16'd2;

  typedef enum logic [3:0] {
    PH_MAGIC1  = 4'd0,
    PH_MAGIC2  = 4'd1,
    PH_METHOD  = 4'd2,
    PH_FLAGS   = 4'd3,
    PH_FIXED   = 4'd4,
    PH_XLEN_LO = 4'd5,
    PH_XLEN_HI = 4'd6,
    PH_XSKIP   = 4'd7,
    PH_NAME    = 4'd8,
    PH_COMMENT = 4'd9,
    PH_HCRC    = 4'd10,
    PH_PAYLOAD = 4'd11,
    PH_ERR_MAG = 4'd12,
    PH_ERR_HDR = 4'd13
  } phase_t;

  typedef enum logic [2:0] {
    ST_HDR      = 3'd0,
    ST_NAME     = 3'd1,
    ST_DONE     = 3'd2,
    ST_PAYLOAD  = 3'd3,
    ST_BADMAGIC = 3'd4,
    ST_BADHDR   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    SEC_EXTRA   = 3'd0,
    SEC_NAME    = 3'd1,
    SEC_COMMENT = 3'd2,
    SEC_HCRC    = 3'd3,
    SEC_NONE    = 3'd4
  } section_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_stream;
  } item_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] out_byte;
  } result_t;

  typedef struct packed {
    phase_t phase;
    logic   load_crc;
    logic   done;
  } section_sel_t;

  // Picks the first optional header section at or after the given one whose flag is set, else the payload.
  function automatic section_sel_t enter_section(input section_t from,
                                                 input logic [7:0] flags);
    section_sel_t sel;
    sel = '{phase: PH_PAYLOAD, load_crc: 1'b0, done: 1'b1};
    if (from <= SEC_EXTRA && (flags & FLG_EXTRA) != 8'd0) begin
      sel = '{phase: PH_XLEN_LO, load_crc: 1'b0, done: 1'b0};
    end else if (from <= SEC_NAME && (flags & FLG_NAME) != 8'd0) begin
      sel = '{phase: PH_NAME, load_crc: 1'b0, done: 1'b0};
    end else if (from <= SEC_COMMENT && (flags & FLG_COMMENT) != 8'd0) begin
      sel = '{phase: PH_COMMENT, load_crc: 1'b0, done: 1'b0};
    end else if (from <= SEC_HCRC && (flags & FLG_HCRC) != 8'd0) begin
      sel = '{phase: PH_HCRC, load_crc: 1'b1, done: 1'b0};
    end
    return sel;
  endfunction

endpackage

`default_nettype wire

### src/gzip_header_parser.sv
// ----------------------------------------------------------------------------
// gzip member header parser
// Walks the RFC 1952 member header one byte per transaction and reports a
// status for every byte, and echoes each byte beside its status.
//
//   channel   direction  handshake                   payload
//   item      in         item_valid / item_ready     item_t   (byte, start)
//   result    out        result_valid / result_ready result_t (status, byte)
//
// One byte is accepted per cycle; its status appears in the result register
// on the next cycle. The parse state and the result register update together.
// Bytes keep flowing while a result waits, as long as the result is taken in
// the same cycle. Reset empties the result register and restarts the parse.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gzip_header_parser_assert.svh"

module gzip_header_parser
  import ghp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_ready,
  input  wire item_t   item,
  output logic         result_valid,
  input  wire logic    result_ready,
  output result_t      result
);

  phase_t       phase, phase_next;
  logic [15:0]  skip_count, skip_count_next;
  logic [7:0]   header_flags, header_flags_next;
  logic [7:0]   extra_len_low, extra_len_low_next;
  result_t      result_next;

  phase_t       phase_cur;
  logic [15:0]  skip_cur;
  logic [7:0]   flags_cur;
  logic [7:0]   xlow_cur;
  logic [7:0]   b;
  logic         accept;
  logic         skip_end;
  logic [15:0]  xlen;
  section_sel_t sel;
  section_t     sec_from;
  logic         sec_go;
  status_t      st;

  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;
  assign b          = item.in_byte;

  assign phase_cur = item.start_of_stream ? PH_MAGIC1 : phase;
  assign skip_cur  = item.start_of_stream ? 16'd0 : skip_count;
  assign flags_cur = item.start_of_stream ? 8'd0 : header_flags;
  assign xlow_cur  = item.start_of_stream ? 8'd0 : extra_len_low;
  assign skip_end  = (skip_cur <= 16'd1);
  assign xlen      = {b, xlow_cur};
  assign sel       = enter_section(sec_from, flags_cur);

  always_comb begin
    phase_next         = phase_cur;
    skip_count_next    = skip_cur;
    header_flags_next  = flags_cur;
    extra_len_low_next = xlow_cur;
    st                 = ST_HDR;
    sec_from           = SEC_NONE;
    sec_go             = 1'b0;

    case (phase_cur)
      PH_MAGIC1: begin
        if (b == MAGIC_FIRST) begin
          phase_next = PH_MAGIC2;
        end else begin
          phase_next = PH_ERR_MAG;
          st         = ST_BADMAGIC;
        end
      end
      PH_MAGIC2: begin
        if (b == MAGIC_SECOND) begin
          phase_next = PH_METHOD;
        end else begin
          phase_next = PH_ERR_MAG;
          st         = ST_BADMAGIC;
        end
      end
      PH_METHOD: begin
        if (b == METHOD_DEFLATE) begin
          phase_next = PH_FLAGS;
        end else begin
          phase_next = PH_ERR_HDR;
          st         = ST_BADHDR;
        end
      end
      PH_FLAGS: begin
        if ((b & FLG_RESERVED) != 8'd0) begin
          phase_next = PH_ERR_HDR;
          st         = ST_BADHDR;
        end else begin
          header_flags_next = b;
          skip_count_next   = FIXED_LEN;
          phase_next        = PH_FIXED;
        end
      end
      PH_FIXED: begin
        skip_count_next = skip_end ? 16'd0 : skip_cur - 16'd1;
        sec_from        = SEC_EXTRA;
        sec_go          = skip_end;
      end
      PH_XLEN_LO: begin
        extra_len_low_next = b;
        phase_next         = PH_XLEN_HI;
      end
      PH_XLEN_HI: begin
        skip_count_next = xlen;
        sec_from        = SEC_NAME;
        sec_go          = (xlen == 16'd0);
        if (xlen != 16'd0) begin
          phase_next = PH_XSKIP;
        end
      end
      PH_XSKIP: begin
        skip_count_next = skip_end ? 16'd0 : skip_cur - 16'd1;
        sec_from        = SEC_NAME;
        sec_go          = skip_end;
      end
      PH_NAME: begin
        sec_from = SEC_COMMENT;
        sec_go   = (b == 8'd0);
        if (b != 8'd0) begin
          st = ST_NAME;
        end
      end
      PH_COMMENT: begin
        sec_from = SEC_HCRC;
        sec_go   = (b == 8'd0);
      end
      PH_HCRC: begin
        skip_count_next = skip_end ? 16'd0 : skip_cur - 16'd1;
        sec_from        = SEC_NONE;
        sec_go          = skip_end;
      end
      PH_PAYLOAD: begin
        st = ST_PAYLOAD;
      end
      PH_ERR_HDR: begin
        st = ST_BADHDR;
      end
      default: begin
        phase_next = PH_ERR_MAG;
        st         = ST_BADMAGIC;
      end
    endcase

    if (sec_go) begin
      phase_next = sel.phase;
      if (sel.load_crc) begin
        skip_count_next = HCRC_LEN;
      end
      if (sel.done) begin
        st = ST_DONE;
      end
    end

    result_next = '{status: st, out_byte: b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_MAGIC1;
      skip_count    <= 16'd0;
      header_flags  <= 8'd0;
      extra_len_low <= 8'd0;
      result_valid  <= 1'b0;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        skip_count    <= skip_count_next;
        header_flags  <= header_flags_next;
        extra_len_low <= extra_len_low_next;
        result_valid  <= 1'b1;
      end else if (result_ready) begin
        result_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  `GHP_ASSERT(a_ready_when_empty, !result_valid |-> item_ready, "input stalled with empty output")
  `GHP_ASSERT(a_hdr_error_sticky,
    accept && phase == PH_ERR_HDR && !item.start_of_stream
      |=> result_valid && result.status == ST_BADHDR,
    "header error did not persist")
  `GHP_ASSERT(a_restart_magic,
    accept && item.start_of_stream && item.in_byte != MAGIC_FIRST
      |=> result_valid && result.status == ST_BADMAGIC,
    "restart with wrong first byte not flagged")
  `GHP_ASSERT(a_payload_no_skip, phase == PH_PAYLOAD |-> skip_count == 16'd0,
    "skip count left over in payload")
  `GHP_ASSERT_ALWAYS(a_reset_empty, rst |=> !result_valid, "result valid after reset")

endmodule

`default_nettype wire
